// ===== rtl/dpp_pkg.sv =====
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants of the depth pixel to point converter.
// ----------------------------------------------------------------------------
package dpp_pkg;

  localparam int unsigned COORD_W    = 11;
  localparam int unsigned DEPTH_W    = 11;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned COORD_OUT_W = 24;

  // raw codes at or above DEPTH_CODES-1 carry no depth
  localparam int unsigned DEPTH_CODES = 2048;
  localparam logic [12:0] DEPTH_LIMIT = 13'(DEPTH_CODES - 1);

  localparam logic [11:0] SIZE_MAX = 12'd2048;

  // z = 65536e10 / (Z_OFFSET - Z_SLOPE * d), all scaled by 1e10
  localparam logic [35:0] Z_OFFSET = 36'd33309495161;
  localparam logic [24:0] Z_SLOPE  = 25'd30711016;
  localparam logic [49:0] Z_NUM    = 50'd655360000000000;

  localparam logic [23:0] Q_MAX_POS = 24'h7fffff;
  localparam logic [23:0] Q_MIN_NEG = 24'h800000;

  // rounding half of the Q44 to Q16 step
  localparam logic [59:0] ROUND_HALF = 60'd134217728;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH    = 3'd0,
    REG_FRAME_HEIGHT   = 3'd1,
    REG_SUBSAMPLE_STEP = 3'd2,
    REG_CENTER_X       = 3'd3,
    REG_CENTER_Y       = 3'd4,
    REG_INV_FOCAL_X    = 3'd5,
    REG_INV_FOCAL_Y    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] frame_width;
    logic [11:0] frame_height;
    logic [4:0]  subsample_step;
    logic [14:0] center_x;
    logic [14:0] center_y;
    logic [19:0] inv_focal_x;
    logic [19:0] inv_focal_y;
  } cfg_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] raw_depth;
    logic [15:0]        dx;
    logic [15:0]        dy;
    logic               frame_end;
  } item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SETUP,
    BK_PRESCALE,
    BK_DIVIDE,
    BK_SIGN,
    BK_MUL_AB,
    BK_MUL_LO,
    BK_MUL_HI,
    BK_ROUND
  } back_state_e;

endpackage

// ===== rtl/dpp_front.sv =====
// ----------------------------------------------------------------------------
// dpp_front
// Raster position tracking, subsample selection and pixel offset forming.
// ----------------------------------------------------------------------------
module dpp_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dpp_pkg::cfg_t               cfg_i,
  input  logic                        cfg_we_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dpp_pkg::DEPTH_W-1:0] raw_depth_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output dpp_pkg::item_t              item_o
);

  localparam int unsigned NumLanes = 4;
  localparam logic [3:0] RecalcCycles = 4'(dpp_pkg::COORD_W);

  logic [11:0] width_eff, height_eff;
  logic [dpp_pkg::COORD_W-1:0] width_m1, height_m1;
  logic [4:0] step_eff;
  logic [4:0] step_m1;

  logic [dpp_pkg::COORD_W-1:0] col_q, col_d, row_q, row_d;
  logic [4:0] col_ph_q, col_ph_d, row_ph_q, row_ph_d;
  logic [dpp_pkg::COORD_W-1:0] last_col_q, last_row_q;

  logic       start_q;
  logic [3:0] cnt_q;
  logic [dpp_pkg::COORD_W-1:0] opnd_q [NumLanes];
  logic [4:0] rem_q [NumLanes];
  logic [4:0] rem_d [NumLanes];
  logic [5:0] trial [NumLanes];

  logic busy, keep, accept, col_wrap, row_wrap;

  always_comb begin
    if (cfg_i.frame_width == '0) begin
      width_eff = 12'd1;
    end else if (cfg_i.frame_width > dpp_pkg::SIZE_MAX) begin
      width_eff = dpp_pkg::SIZE_MAX;
    end else begin
      width_eff = cfg_i.frame_width;
    end
    if (cfg_i.frame_height == '0) begin
      height_eff = 12'd1;
    end else if (cfg_i.frame_height > dpp_pkg::SIZE_MAX) begin
      height_eff = dpp_pkg::SIZE_MAX;
    end else begin
      height_eff = cfg_i.frame_height;
    end
    step_eff  = (cfg_i.subsample_step == '0) ? 5'd1 : cfg_i.subsample_step;
  end

  assign width_m1  = dpp_pkg::COORD_W'(width_eff - 12'd1);
  assign height_m1 = dpp_pkg::COORD_W'(height_eff - 12'd1);
  assign step_m1   = step_eff - 5'd1;

  // remainder by the step, one bit a cycle on four lanes
  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      trial[i] = {rem_q[i], opnd_q[i][dpp_pkg::COORD_W-1]};
      rem_d[i] = (trial[i] >= 6'(step_eff)) ? 5'(trial[i] - 6'(step_eff)) : trial[i][4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b1;
      cnt_q   <= '0;
    end else begin
      start_q <= cfg_we_i;
      if (start_q) begin
        cnt_q <= RecalcCycles;
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_q) begin
      opnd_q[0] <= col_q;
      opnd_q[1] <= row_q;
      opnd_q[2] <= width_m1;
      opnd_q[3] <= height_m1;
      for (int i = 0; i < NumLanes; i++) begin
        rem_q[i] <= '0;
      end
    end else if (cnt_q != '0) begin
      for (int i = 0; i < NumLanes; i++) begin
        opnd_q[i] <= {opnd_q[i][dpp_pkg::COORD_W-2:0], 1'b0};
        rem_q[i]  <= rem_d[i];
      end
    end
  end

  assign busy       = start_q || (cnt_q != '0);
  assign keep       = (col_ph_q == '0) && (row_ph_q == '0);
  assign in_ready_o = !busy && !cfg_we_i && (!keep || !queue_full_i);
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = accept && keep;

  assign item_o.raw_depth = raw_depth_i;
  assign item_o.dx        = {1'b0, col_q, 4'b0} - {1'b0, cfg_i.center_x};
  assign item_o.dy        = {1'b0, row_q, 4'b0} - {1'b0, cfg_i.center_y};
  assign item_o.frame_end = (col_q == last_col_q) && (row_q == last_row_q);

  assign col_wrap = col_q >= width_m1;
  assign row_wrap = row_q >= height_m1;

  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    col_ph_d = col_ph_q;
    row_ph_d = row_ph_q;
    if (col_wrap) begin
      col_d    = '0;
      col_ph_d = '0;
      if (row_wrap) begin
        row_d    = '0;
        row_ph_d = '0;
      end else begin
        row_d    = row_q + 1'b1;
        row_ph_d = (row_ph_q == step_m1) ? 5'd0 : row_ph_q + 5'd1;
      end
    end else begin
      col_d    = col_q + 1'b1;
      col_ph_d = (col_ph_q == step_m1) ? 5'd0 : col_ph_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      col_ph_q   <= '0;
      row_ph_q   <= '0;
      last_col_q <= '0;
      last_row_q <= '0;
    end else if (cnt_q == 4'd1) begin
      col_ph_q   <= rem_d[0];
      row_ph_q   <= rem_d[1];
      last_col_q <= width_m1 - dpp_pkg::COORD_W'(rem_d[2]);
      last_row_q <= height_m1 - dpp_pkg::COORD_W'(rem_d[3]);
    end else if (accept) begin
      col_q    <= col_d;
      row_q    <= row_d;
      col_ph_q <= col_ph_d;
      row_ph_q <= row_ph_d;
    end
  end

endmodule

// ===== rtl/dpp_fifo.sv =====
// ----------------------------------------------------------------------------
// dpp_fifo
// Short queue of kept pixels between the front and the back.
// ----------------------------------------------------------------------------
module dpp_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dpp_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output dpp_pkg::item_t item_o
);

  localparam int unsigned AddrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam logic [AddrW-1:0]  LastAddr  = AddrW'(DEPTH - 1);
  localparam logic [CountW-1:0] FullCount = CountW'(DEPTH);

  dpp_pkg::item_t mem_q [DEPTH];
  logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0] count_q;
  logic do_push, do_pop;

  assign full_o  = count_q == FullCount;
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/dpp_back.sv =====
// ----------------------------------------------------------------------------
// dpp_back
// Depth code to metres through a radix-2 divider, then x and y projection.
// ----------------------------------------------------------------------------
module dpp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dpp_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  dpp_pkg::item_t q_item_i,
  output logic           q_pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [71:0]    m_data_o,
  output logic           m_last_o
);

  dpp_pkg::back_state_e state_q, state_d;

  dpp_pkg::item_t item_q;
  logic        den_neg_q, invalid_q, sat_q;
  logic [34:0] mag_q;
  logic [49:0] rem_q;
  logic [58:0] dvs_q;
  logic [23:0] quo_q;
  logic [4:0]  cnt_q;
  logic [23:0] z_q;
  logic [38:0] abx_q, aby_q;
  logic        xneg_q, yneg_q;
  logic [39:0] lox_q, loy_q;
  logic [38:0] hix_q, hiy_q;

  logic [35:0] slope_prod;
  logic signed [36:0] den;
  logic [34:0] den_mag;
  logic        invalid_d;
  logic [49:0] numer;
  logic        sat_pre, div_ge;
  logic [23:0] z_d, zmag;
  logic [14:0] dxmag, dymag;
  logic        out_free, out_load;
  logic        m_valid_q, m_last_q;
  logic [71:0] m_data_q;

  function automatic logic [23:0] round_sat(input logic [39:0] lo, input logic [38:0] hi,
                                            input logic neg);
    logic [59:0] sum;
    logic [31:0] mag;
    logic [23:0] res;
    sum = {1'b0, hi, 20'b0} + 60'(lo) + dpp_pkg::ROUND_HALF;
    mag = sum[59:28];
    if (neg) begin
      res = (mag > 32'(dpp_pkg::Q_MIN_NEG)) ? dpp_pkg::Q_MIN_NEG : 24'(-mag);
    end else begin
      res = (mag > 32'(dpp_pkg::Q_MAX_POS)) ? dpp_pkg::Q_MAX_POS : mag[23:0];
    end
    return res;
  endfunction

  assign slope_prod = dpp_pkg::Z_SLOPE * item_q.raw_depth;
  assign den        = $signed({1'b0, dpp_pkg::Z_OFFSET}) - $signed({1'b0, slope_prod});
  assign den_mag    = den[36] ? 35'(-den) : den[34:0];
  assign invalid_d  = {2'b0, item_q.raw_depth} >= dpp_pkg::DEPTH_LIMIT;
  assign numer      = dpp_pkg::Z_NUM + 50'(mag_q >> 1);
  assign sat_pre    = {9'b0, numer} >= {mag_q, 24'b0};
  assign div_ge     = {9'b0, rem_q} >= dvs_q;

  always_comb begin
    if (invalid_q) begin
      z_d = '0;
    end else if (!den_neg_q) begin
      z_d = (sat_q || quo_q > dpp_pkg::Q_MAX_POS) ? dpp_pkg::Q_MAX_POS : quo_q;
    end else begin
      z_d = (sat_q || quo_q > dpp_pkg::Q_MIN_NEG) ? dpp_pkg::Q_MIN_NEG : 24'(-quo_q);
    end
  end

  assign zmag  = z_q[23] ? 24'(-z_q) : z_q;
  assign dxmag = item_q.dx[15] ? 15'(-item_q.dx) : item_q.dx[14:0];
  assign dymag = item_q.dy[15] ? 15'(-item_q.dy) : item_q.dy[14:0];

  assign out_free = !m_valid_q || m_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dpp_pkg::BK_IDLE:     if (q_valid_i) state_d = dpp_pkg::BK_SETUP;
      dpp_pkg::BK_SETUP:    state_d = dpp_pkg::BK_PRESCALE;
      dpp_pkg::BK_PRESCALE: begin
        state_d = (invalid_q || sat_pre) ? dpp_pkg::BK_SIGN : dpp_pkg::BK_DIVIDE;
      end
      dpp_pkg::BK_DIVIDE:   if (cnt_q == '0) state_d = dpp_pkg::BK_SIGN;
      dpp_pkg::BK_SIGN:     state_d = dpp_pkg::BK_MUL_AB;
      dpp_pkg::BK_MUL_AB:   state_d = dpp_pkg::BK_MUL_LO;
      dpp_pkg::BK_MUL_LO:   state_d = dpp_pkg::BK_MUL_HI;
      dpp_pkg::BK_MUL_HI:   state_d = dpp_pkg::BK_ROUND;
      dpp_pkg::BK_ROUND:    if (out_free) state_d = dpp_pkg::BK_IDLE;
      default:              state_d = dpp_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o  = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      dpp_pkg::BK_IDLE:  q_pop_o  = q_valid_i;
      dpp_pkg::BK_ROUND: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dpp_pkg::BK_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == dpp_pkg::BK_PRESCALE) begin
        cnt_q <= 5'd23;
      end else if (state_q == dpp_pkg::BK_DIVIDE) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      dpp_pkg::BK_IDLE: begin
        if (q_pop_o) item_q <= q_item_i;
      end
      dpp_pkg::BK_SETUP: begin
        den_neg_q <= den[36];
        mag_q     <= den_mag;
        invalid_q <= invalid_d;
      end
      dpp_pkg::BK_PRESCALE: begin
        rem_q <= numer;
        dvs_q <= {1'b0, mag_q, 23'b0};
        quo_q <= '0;
        sat_q <= sat_pre;
      end
      dpp_pkg::BK_DIVIDE: begin
        if (div_ge) rem_q <= 50'({9'b0, rem_q} - dvs_q);
        quo_q <= {quo_q[22:0], div_ge};
        dvs_q <= dvs_q >> 1;
      end
      dpp_pkg::BK_SIGN: begin
        z_q <= z_d;
      end
      dpp_pkg::BK_MUL_AB: begin
        abx_q  <= dxmag * zmag;
        aby_q  <= dymag * zmag;
        xneg_q <= item_q.dx[15] ^ z_q[23];
        yneg_q <= item_q.dy[15] ^ z_q[23];
      end
      dpp_pkg::BK_MUL_LO: begin
        lox_q <= abx_q[19:0] * cfg_i.inv_focal_x;
        loy_q <= aby_q[19:0] * cfg_i.inv_focal_y;
      end
      dpp_pkg::BK_MUL_HI: begin
        hix_q <= abx_q[38:20] * cfg_i.inv_focal_x;
        hiy_q <= aby_q[38:20] * cfg_i.inv_focal_y;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {z_q, round_sat(loy_q, hiy_q, yneg_q), round_sat(lox_q, hix_q, xneg_q)};
      m_last_q <= item_q.frame_end;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_last_o  = m_last_q;

endmodule

// ===== rtl/depth_pixel_to_point.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Back-projects subsampled raw depth pixels to signed Q8.16 x, y, z points.
// ----------------------------------------------------------------------------
// path: a kept pixel passes the queue, setup, prescale, the 24-step radix-2 divider,
//   sign, multiply and rounding; invalid or saturating depth codes skip the divider
// flow: dropped pixels one per cycle unless the input stalls; the back takes a kept
//   point only once done with the last, a FIFO_DEPTH entry queue absorbing bursts
// reset: counters cleared, registers at defaults; input stalls after reset and
//   after each register write while subsample phases reload
module depth_pixel_to_point #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dpp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // raw_depth
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [71:0]                      m_axis_tdata,  // point_x, point_y, point_z
  output logic                             m_axis_tlast
);

  dpp_pkg::cfg_t  cfg_q;
  dpp_pkg::item_t front_item, queue_item;
  logic push, queue_full, queue_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width    <= 12'd640;
      cfg_q.frame_height   <= 12'd480;
      cfg_q.subsample_step <= 5'd4;
      cfg_q.center_x       <= 15'd5429;
      cfg_q.center_y       <= 15'd3884;
      cfg_q.inv_focal_x    <= 20'd28235;
      cfg_q.inv_focal_y    <= 20'd28386;
    end else if (cfg_we_i) begin
      unique case (dpp_pkg::cfg_reg_e'(cfg_idx_i))
        dpp_pkg::REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data_i[11:0];
        dpp_pkg::REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data_i[11:0];
        dpp_pkg::REG_SUBSAMPLE_STEP: cfg_q.subsample_step <= cfg_data_i[4:0];
        dpp_pkg::REG_CENTER_X:       cfg_q.center_x       <= cfg_data_i[14:0];
        dpp_pkg::REG_CENTER_Y:       cfg_q.center_y       <= cfg_data_i[14:0];
        dpp_pkg::REG_INV_FOCAL_X:    cfg_q.inv_focal_x    <= cfg_data_i;
        dpp_pkg::REG_INV_FOCAL_Y:    cfg_q.inv_focal_y    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dpp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cfg_we_i     (cfg_we_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .raw_depth_i  (s_axis_tdata[dpp_pkg::DEPTH_W-1:0]),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  dpp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  dpp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (queue_valid),
    .q_item_i  (queue_item),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

// ===== rtl/dpp_checker.sv =====
// ----------------------------------------------------------------------------
// dpp_checker
// Port-level checks of the depth pixel to point converter.
// ----------------------------------------------------------------------------
module dpp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // zero depth forces zero x and y
  a_zero_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[71:48] == 24'd0) |-> (m_axis_tdata[47:0] == 48'd0))
    else $error("nonzero x or y with zero depth");

  // no pixel beat while a register write lands
  a_cfg_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !s_axis_tready)
    else $error("input ready during register write");

  // front stalls right after a register write while phases reload
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !s_axis_tready)
    else $error("input ready right after register write");

endmodule

bind depth_pixel_to_point dpp_checker u_dpp_checker (.*);

// ===== dv/depth_pixel_to_point_checker.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_to_point_checker
// Watches the register port and both streams of the depth back-projection
// block. It keeps its own copy of the registers and the raster counters,
// predicts the point for every kept pixel beat and compares each output beat
// field by field against the oldest predicted point.
// ----------------------------------------------------------------------------
module depth_pixel_to_point_checker
  import dpp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [15:0]           s_tdata_i,   // raw_depth
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [71:0]           m_tdata_i,   // point_x, point_y, point_z
  input  logic                  m_tlast_i,
  output int unsigned           mismatches_o,
  output int unsigned           points_pending_o,
  output int unsigned           points_checked_o,
  output int unsigned           frame_ends_o
);

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic               frame_end;
  } point_t;

  localparam cfg_t DEFAULT_CFG = '{
    frame_width:    12'd640,
    frame_height:   12'd480,
    subsample_step: 5'd4,
    center_x:       15'd5429,
    center_y:       15'd3884,
    inv_focal_x:    20'd28235,
    inv_focal_y:    20'd28386
  };

  localparam longint          Z_BASE       = 64'sd33309495161;
  localparam longint          Z_PER_CODE   = 64'sd30711016;
  localparam longint unsigned Z_SCALE      = 64'd655360000000000;
  localparam longint          Q16_MAX      = 64'sd8388607;
  localparam longint          Q16_MIN      = -64'sd8388608;
  localparam longint unsigned Q16_MIN_MAG  = 64'd8388608;
  localparam longint unsigned Q44_HALF     = 64'd134217728;
  localparam int unsigned     CODE_NO_DATA = 2047;
  localparam int unsigned     SIZE_LIMIT   = 2048;
  localparam int unsigned     COUNT_MASK   = 'h7ff;
  localparam int unsigned     REPORT_LINES = 20;

  cfg_t        regs;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned mismatch_total;
  int unsigned checked_total;
  int unsigned frame_end_total;
  point_t      expected_points[$];

  function automatic longint z_from_code(input logic [10:0] code);
    longint          den;
    longint unsigned mag;
    longint unsigned q;
    if (code >= CODE_NO_DATA) return 0;
    den = Z_BASE - Z_PER_CODE * longint'(code);
    if (den == 0) return Q16_MAX;
    mag = (den < 0) ? -den : den;
    q = (Z_SCALE + mag / 2) / mag;
    if (den > 0) return (q > Q16_MAX) ? Q16_MAX : longint'(q);
    return (q > Q16_MIN_MAG) ? Q16_MIN : -longint'(q);
  endfunction

  function automatic longint project_axis(input longint offset, input longint z,
                                          input longint unsigned inv);
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    bit              neg;
    a = (offset < 0) ? -offset : offset;
    b = (z < 0) ? -z : z;
    r = (a * b * inv + Q44_HALF) >> 28;
    neg = (offset < 0) != (z < 0);
    if (neg) return (r > Q16_MIN_MAG) ? Q16_MIN : -longint'(r);
    return (r > Q16_MAX) ? Q16_MAX : longint'(r);
  endfunction

  function automatic int unsigned clamp_size(input logic [11:0] size);
    if (size == 0) return 1;
    if (size > SIZE_LIMIT) return SIZE_LIMIT;
    return size;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (mismatch_total < REPORT_LINES)
      $display("mismatch at point %0d: %s is %0d, expected %0d",
               checked_total, field, got, want);
    mismatch_total++;
  endtask

  task automatic accept_pixel(input logic [10:0] code);
    int unsigned w;
    int unsigned h;
    int unsigned step;
    int unsigned last_col;
    int unsigned last_row;
    longint      z;
    point_t      pt;
    w = clamp_size(regs.frame_width);
    h = clamp_size(regs.frame_height);
    step = (regs.subsample_step == 0) ? 1 : regs.subsample_step;
    if ((col_pos % step == 0) && (row_pos % step == 0)) begin
      z = z_from_code(code);
      last_col = ((w - 1) / step) * step;
      last_row = ((h - 1) / step) * step;
      pt.x = 24'(project_axis(longint'(col_pos) * 16 - longint'(regs.center_x), z,
                              regs.inv_focal_x));
      pt.y = 24'(project_axis(longint'(row_pos) * 16 - longint'(regs.center_y), z,
                              regs.inv_focal_y));
      pt.z = 24'(z);
      pt.frame_end = (col_pos == last_col) && (row_pos == last_row);
      expected_points.push_back(pt);
    end
    if (col_pos >= w - 1) begin
      col_pos = 0;
      row_pos = (row_pos >= h - 1) ? 0 : ((row_pos + 1) & COUNT_MASK);
    end else begin
      col_pos = (col_pos + 1) & COUNT_MASK;
    end
  endtask

  task automatic check_point(input point_t got);
    point_t want;
    if (expected_points.size() == 0) begin
      report_mismatch("point with none pending, z", got.z, 0);
      return;
    end
    want = expected_points.pop_front();
    if (got.x != want.x) report_mismatch("point_x", got.x, want.x);
    if (got.y != want.y) report_mismatch("point_y", got.y, want.y);
    if (got.z != want.z) report_mismatch("point_z", got.z, want.z);
    if (got.frame_end != want.frame_end)
      report_mismatch("frame_end", got.frame_end, want.frame_end);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    point_t got;
    if (!rst_ni) begin
      regs = DEFAULT_CFG;
      col_pos = 0;
      row_pos = 0;
      mismatch_total = 0;
      checked_total = 0;
      frame_end_total = 0;
      expected_points.delete();
      mismatches_o <= 0;
      points_pending_o <= 0;
      points_checked_o <= 0;
      frame_ends_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_FRAME_WIDTH:    regs.frame_width    = cfg_data_i[11:0];
          REG_FRAME_HEIGHT:   regs.frame_height   = cfg_data_i[11:0];
          REG_SUBSAMPLE_STEP: regs.subsample_step = cfg_data_i[4:0];
          REG_CENTER_X:       regs.center_x       = cfg_data_i[14:0];
          REG_CENTER_Y:       regs.center_y       = cfg_data_i[14:0];
          REG_INV_FOCAL_X:    regs.inv_focal_x    = cfg_data_i[19:0];
          REG_INV_FOCAL_Y:    regs.inv_focal_y    = cfg_data_i[19:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) accept_pixel(s_tdata_i[10:0]);
      if (m_tvalid_i && m_tready_i) begin
        got.x = m_tdata_i[23:0];
        got.y = m_tdata_i[47:24];
        got.z = m_tdata_i[71:48];
        got.frame_end = m_tlast_i;
        check_point(got);
        checked_total++;
        if (m_tlast_i) frame_end_total++;
      end
      mismatches_o <= mismatch_total;
      points_pending_o <= expected_points.size();
      points_checked_o <= checked_total;
      frame_ends_o <= frame_end_total;
    end
  end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the depth back-projection block. Streams raw depth
// pixels in bursts through a series of register settings, from the reset
// defaults through size, step, center and focal extremes to random settings,
// while the output side stalls on its own pattern, once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
  import dpp_pkg::*;

  typedef enum int unsigned {RX_FREE, RX_HALF, RX_SPARSE} rx_mode_e;

  localparam int unsigned DRAIN_CYCLES  = 48;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned TARGET_PIXELS = 1100;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [10:0] CODE_NO_DATA    = 11'd2047;
  localparam logic [10:0] CODE_LAST_VALID = 11'd2046;
  localparam logic [10:0] CODE_NEAR_POLE  = 11'd1080;
  localparam logic [10:0] CODE_PAST_POLE  = 11'd1090;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [71:0]           m_axis_tdata;
  logic                  m_axis_tlast;

  int unsigned mismatches;
  int unsigned points_pending;
  int unsigned points_checked;
  int unsigned frame_ends;

  int unsigned pixels_sent = 0;
  int unsigned settings_used = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;

  logic [10:0] default_codes [0:9] = '{
    11'd1084, 11'd3, 11'd2, 11'd1, 11'd2047, 11'd700, 11'd800, 11'd900, 11'd0, 11'd2046
  };
  logic [10:0] edge_codes [0:14] = '{
    11'd1084, 11'd1085, 11'd0, 11'd2047, 11'd2046, 11'd1, 11'd1083, 11'd1086,
    11'd2045, 11'd1024, 11'd512, 11'd256, 11'd1500, 11'd2000, 11'd7
  };

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  depth_pixel_to_point i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  depth_pixel_to_point_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_tvalid_i      (s_axis_tvalid),
    .s_tready_i      (s_axis_tready),
    .s_tdata_i       (s_axis_tdata),
    .m_tvalid_i      (m_axis_tvalid),
    .m_tready_i      (m_axis_tready),
    .m_tdata_i       (m_axis_tdata),
    .m_tlast_i       (m_axis_tlast),
    .mismatches_o    (mismatches),
    .points_pending_o(points_pending),
    .points_checked_o(points_checked),
    .frame_ends_o    (frame_ends)
  );

  function automatic cfg_t make_cfg(input logic [11:0] w, input logic [11:0] h,
                                    input logic [4:0] step, input logic [14:0] cx,
                                    input logic [14:0] cy, input logic [19:0] ifx,
                                    input logic [19:0] ify);
    cfg_t c;
    c.frame_width = w;
    c.frame_height = h;
    c.subsample_step = step;
    c.center_x = cx;
    c.center_y = cy;
    c.inv_focal_x = ifx;
    c.inv_focal_y = ify;
    return c;
  endfunction

  function automatic logic [11:0] pick_size();
    case ($urandom_range(0, 9))
      0:       return 12'($urandom_range(13, 4095));
      1:       return 12'd0;
      default: return 12'($urandom_range(1, 12));
    endcase
  endfunction

  function automatic logic [14:0] pick_center();
    if ($urandom_range(0, 3) == 0) return 15'($urandom_range(0, 32767));
    return 15'($urandom_range(0, 256));
  endfunction

  function automatic logic [19:0] pick_inv_focal();
    if ($urandom_range(0, 3) == 0) return 20'($urandom_range(0, 1048575));
    return 20'($urandom_range(20000, 40000));
  endfunction

  function automatic cfg_t random_settings();
    logic [4:0] step;
    step = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 4));
    return make_cfg(pick_size(), pick_size(), step, pick_center(), pick_center(),
                    pick_inv_focal(), pick_inv_focal());
  endfunction

  function automatic logic [10:0] pick_code();
    case ($urandom_range(0, 9))
      0:       return CODE_NO_DATA;
      1:       return CODE_LAST_VALID;
      2:       return 11'($urandom_range(CODE_NEAR_POLE, CODE_PAST_POLE));
      3:       return 11'd0;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  // unused upper bits of a register write carry noise when asked
  function automatic logic [CFG_DATA_W-1:0] pad(input logic [CFG_DATA_W-1:0] field,
                                                input int unsigned bits, input bit noise);
    return field | (noise ? CFG_DATA_W'($urandom << bits) : '0);
  endfunction

  task automatic send_pixel(input logic [10:0] code);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'd0, code};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pixels_sent++;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= 16'($urandom);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 12);
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (points_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input cfg_t c, input bit noise);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, pad(CFG_DATA_W'(c.frame_width), 12, noise));
    write_reg(REG_FRAME_HEIGHT, pad(CFG_DATA_W'(c.frame_height), 12, noise));
    write_reg(REG_SUBSAMPLE_STEP, pad(CFG_DATA_W'(c.subsample_step), 5, noise));
    write_reg(REG_CENTER_X, pad(CFG_DATA_W'(c.center_x), 15, noise));
    write_reg(REG_CENTER_Y, pad(CFG_DATA_W'(c.center_y), 15, noise));
    write_reg(REG_INV_FOCAL_X, c.inv_focal_x);
    write_reg(REG_INV_FOCAL_Y, c.inv_focal_y);
    if (noise) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pixel(pick_code());
  endtask

  initial begin : receiver
    rx_mode_e    mode;
    int unsigned span;
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_done = 1'b1;
      end
      span = $urandom_range(10, 150);
      mode = rx_mode_e'($urandom_range(0, 2));
      repeat (span) begin
        case (mode)
          RX_FREE: m_axis_tready <= 1'b1;
          RX_HALF: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk_i);
        if (hold_req && !hold_done) break;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles, %0d points pending",
               idle_cycles, points_pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned i;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: kept columns 0, 4 and 8 of the first row
    for (i = 0; i < 10; i++) send_pixel(default_codes[i]);

    // one small frame, every pixel kept, coordinate and depth extremes
    apply_settings(make_cfg(12'd5, 12'd3, 5'd1, 15'd0, 15'd0, 20'hfffff, 20'hfffff), 1'b0);
    for (i = 0; i < 15; i++) send_pixel(edge_codes[i]);

    // zero sizes and zero step, output held off while the input keeps offering
    apply_settings(make_cfg(12'd0, 12'd0, 5'd0, 15'h7fff, 15'h7fff, 20'd0, 20'd0), 1'b1);
    hold_req <= 1'b1;
    send_random(30);

    // oversize frame, widest step, left mid-row
    apply_settings(make_cfg(12'hfff, 12'd2048, 5'd31, 15'd16000, 15'd12000,
                            20'd28235, 20'd28386), 1'b0);
    send_random(100);

    // counters beyond the new frame width, then beyond the new height
    apply_settings(make_cfg(12'd3, 12'd2048, 5'd1, 15'd24, 15'd40,
                            pick_inv_focal(), pick_inv_focal()), 1'b0);
    send_random(40);
    apply_settings(make_cfg(12'd7, 12'd5, 5'd2, 15'd48, 15'd32,
                            pick_inv_focal(), pick_inv_focal()), 1'b0);
    send_random(40);

    while (pixels_sent < TARGET_PIXELS) begin
      apply_settings(random_settings(), 1'b1);
      send_random($urandom_range(20, 70));
    end

    wait_idle();
    $display("covered %0d pixel beats over %0d register settings",
             pixels_sent, settings_used);
    $display("%0d points checked, %0d frame ends", points_checked, frame_ends);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dpp_pkg.sv
rtl/dpp_front.sv
rtl/dpp_fifo.sv
rtl/dpp_back.sv
rtl/depth_pixel_to_point.sv
rtl/dpp_checker.sv
dv/depth_pixel_to_point_checker.sv
dv/testbench.sv
